// ===== hw/rtl/cbsru_pkg.sv =====
// Package: shared constants and types for the CB-prefix shift/rotate unit.
`timescale 1ns / 1ps
package cbsru_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned SelW    = 3;
  localparam int unsigned FlagW   = 4;
  localparam int unsigned CycW    = 5;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned NumRegs = 8;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  localparam logic [SelW-1:0]  SEL_H   = 3'd4;
  localparam logic [SelW-1:0]  SEL_L   = 3'd5;
  localparam logic [SelW-1:0]  SEL_MEM = 3'd6;

  localparam logic [DataW-1:0] OP_LAST = 8'h37;

  localparam logic [SelW-1:0]  GRP_RLC  = 3'd0;
  localparam logic [SelW-1:0]  GRP_RRC  = 3'd1;
  localparam logic [SelW-1:0]  GRP_RL   = 3'd2;
  localparam logic [SelW-1:0]  GRP_RR   = 3'd3;
  localparam logic [SelW-1:0]  GRP_SLA  = 3'd4;
  localparam logic [SelW-1:0]  GRP_SRA  = 3'd5;

  localparam logic [CycW-1:0]  CYC_NONE = 5'd0;
  localparam logic [CycW-1:0]  CYC_REG  = 5'd8;
  localparam logic [CycW-1:0]  CYC_MEM  = 5'd16;

  localparam logic             ST_DONE   = 1'b0;
  localparam logic             ST_UNIMPL = 1'b1;

  localparam logic             FUNC_EXEC = 1'b0;

  localparam logic [FlagW-1:0] FLAG_Z = 4'b1000;
  localparam logic [DataW-1:0] HI_NIBBLE = 8'hF0;

  typedef logic [DataW-1:0] byte_t;

  typedef struct packed {
    logic [FlagW-1:0] flags_out;
    logic [AddrW-1:0] mem_addr;
    logic             mem_write;
    logic [SelW-1:0]  dest_reg;
    byte_t            result_value;
    logic [CycW-1:0]  cycles;
  } result_t;

endpackage

// ===== hw/rtl/cb_prefix_shift_rotate_unit.sv =====
// Top level: CB-prefix shift, rotate and swap unit with register file and flags.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  in_     | in  | opcode, reg_index, load_value, mem_data, 5 pad       | func
//  out_    | out | cycles, result_value, dest_reg, mem_write, mem_addr,  | status
//          |     | flags_out, 3 pad                                     |
//
// One beat per cycle unless out_ stalls; beats go from input to result register.
// The operand read, shift/rotate and flag update sit between the input register
// and the result register; register file and flags change as a beat advances.
// rst_n is synchronous: registers and flags clear to zero, both stages empty.
// A stalled out_ holds its beat; the input register keeps one more beat.
`timescale 1ns / 1ps
module cb_prefix_shift_rotate_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // opcode[7:0], reg_index[10:8], load_value[18:11], mem_data[26:19], zero[31:27]
  input  logic [cbsru_pkg::InDataW-1:0] in_tdata,
  // func[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // cycles[4:0], result_value[12:5], dest_reg[15:13], mem_write[16],
  // mem_addr[32:17], flags_out[36:33], zero[39:37]
  output logic [cbsru_pkg::OutDataW-1:0] out_tdata,
  // status[0]
  output logic                          out_tuser
);

  logic                           s1_v_r;
  logic                           s1_func_r;
  cbsru_pkg::byte_t               s1_op_r;
  logic [cbsru_pkg::SelW-1:0]     s1_idx_r;
  cbsru_pkg::byte_t               s1_lv_r;
  cbsru_pkg::byte_t               s1_md_r;

  cbsru_pkg::byte_t               reg_file_r [cbsru_pkg::NumRegs];
  logic [cbsru_pkg::FlagW-1:0]    flags_r;

  logic                           out_v_r;
  logic                           out_st_r;
  cbsru_pkg::result_t             out_res_r;

  logic                           advance;
  logic [cbsru_pkg::SelW-1:0]     sel;
  cbsru_pkg::byte_t               oldv;
  cbsru_pkg::byte_t               newv;
  logic                           cout;
  logic                           cin;
  logic                           wr_reg;
  logic [cbsru_pkg::SelW-1:0]     wr_idx;
  cbsru_pkg::byte_t               wr_val;
  logic [cbsru_pkg::FlagW-1:0]    flags_nxt;
  logic                           st_nxt;
  cbsru_pkg::result_t             res_nxt;
  cbsru_pkg::byte_t               h_nxt;
  cbsru_pkg::byte_t               l_nxt;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  assign sel  = s1_op_r[cbsru_pkg::SelW-1:0];
  assign oldv = (sel == cbsru_pkg::SEL_MEM) ? s1_md_r : reg_file_r[sel];
  assign cin  = flags_r[0];

  always_comb begin
    case (s1_op_r[5:3])
      cbsru_pkg::GRP_RLC: begin
        cout = oldv[7];
        newv = {oldv[6:0], oldv[7]};
      end
      cbsru_pkg::GRP_RRC: begin
        cout = oldv[0];
        newv = {oldv[0], oldv[7:1]};
      end
      cbsru_pkg::GRP_RL: begin
        cout = oldv[7];
        newv = {oldv[6:0], cin};
      end
      cbsru_pkg::GRP_RR: begin
        cout = oldv[0];
        newv = {cin, oldv[7:1]};
      end
      cbsru_pkg::GRP_SLA: begin
        cout = oldv[7];
        newv = {oldv[6:0], 1'b0};
      end
      cbsru_pkg::GRP_SRA: begin
        cout = oldv[0];
        newv = {oldv[7], oldv[7:1]};
      end
      default: begin
        cout = 1'b0;
        newv = {oldv[3:0], oldv[7:4]};
      end
    endcase
  end

  always_comb begin
    wr_reg    = 1'b0;
    wr_idx    = s1_idx_r;
    wr_val    = s1_lv_r;
    flags_nxt = flags_r;
    st_nxt    = cbsru_pkg::ST_DONE;
    res_nxt.cycles       = cbsru_pkg::CYC_NONE;
    res_nxt.result_value = '0;
    res_nxt.dest_reg     = sel;
    res_nxt.mem_write    = 1'b0;
    if (s1_func_r != cbsru_pkg::FUNC_EXEC) begin
      res_nxt.dest_reg = s1_idx_r;
      if (s1_idx_r == cbsru_pkg::SEL_MEM) begin
        flags_nxt            = s1_lv_r[7:4];
        res_nxt.result_value = s1_lv_r & cbsru_pkg::HI_NIBBLE;
      end else begin
        wr_reg               = 1'b1;
        res_nxt.result_value = s1_lv_r;
      end
    end else if (s1_op_r > cbsru_pkg::OP_LAST) begin
      st_nxt = cbsru_pkg::ST_UNIMPL;
    end else begin
      flags_nxt            = ((newv == '0) ? cbsru_pkg::FLAG_Z : '0)
                             | {{(cbsru_pkg::FlagW-1){1'b0}}, cout};
      res_nxt.result_value = newv;
      if (sel == cbsru_pkg::SEL_MEM) begin
        res_nxt.cycles    = cbsru_pkg::CYC_MEM;
        res_nxt.mem_write = 1'b1;
      end else begin
        res_nxt.cycles = cbsru_pkg::CYC_REG;
        wr_reg         = 1'b1;
        wr_idx         = sel;
        wr_val         = newv;
      end
    end
    h_nxt = (wr_reg && wr_idx == cbsru_pkg::SEL_H) ? wr_val
                                                  : reg_file_r[cbsru_pkg::SEL_H];
    l_nxt = (wr_reg && wr_idx == cbsru_pkg::SEL_L) ? wr_val
                                                  : reg_file_r[cbsru_pkg::SEL_L];
    res_nxt.mem_addr  = {h_nxt, l_nxt};
    res_nxt.flags_out = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      flags_r <= '0;
      for (int i = 0; i < cbsru_pkg::NumRegs; i++) begin
        reg_file_r[i] <= '0;
      end
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        flags_r <= flags_nxt;
        if (wr_reg) begin
          reg_file_r[wr_idx] <= wr_val;
        end
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r <= in_tuser;
      s1_op_r   <= in_tdata[7:0];
      s1_idx_r  <= in_tdata[10:8];
      s1_lv_r   <= in_tdata[18:11];
      s1_md_r   <= in_tdata[26:19];
    end
    if (advance) begin
      out_st_r  <= st_nxt;
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {{(cbsru_pkg::OutDataW - $bits(cbsru_pkg::result_t)){1'b0}},
                       out_res_r};

endmodule

// ===== hw/rtl/cbsru_checker.sv =====
// Checker: port-level assertions for the CB-prefix shift/rotate unit, with bind.
`timescale 1ns / 1ps
module cbsru_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cbsru_pkg::OutDataW-1:0] out_tdata,
  input logic                           out_tuser
);

  logic [cbsru_pkg::CycW-1:0] cyc;
  logic [cbsru_pkg::SelW-1:0] dst;
  logic                       mw;

  assign cyc = out_tdata[4:0];
  assign dst = out_tdata[15:13];
  assign mw  = out_tdata[16];

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result beat present right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> in_tready)
    else $error("input not ready right after reset");

  a_unimpl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == cbsru_pkg::ST_UNIMPL)
      |-> (cyc == cbsru_pkg::CYC_NONE && !mw))
    else $error("unimplemented opcode reports work");

  a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && mw)
      |-> (cyc == cbsru_pkg::CYC_MEM && dst == cbsru_pkg::SEL_MEM
           && out_tuser == cbsru_pkg::ST_DONE))
    else $error("memory write without memory operand");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser)))
    else $error("stalled result beat changed");

endmodule

bind cb_prefix_shift_rotate_unit cbsru_checker u_cbsru_checker (.*);
